/* src/wthe_pkg.sv */
// Package of the weighted threshold histogram equalizer: constants, tables, shared types.
`default_nettype none
package wthe_pkg;

  localparam int GREY_LEVELS_DEF = 256;
  localparam int MAX_PIXELS_DEF  = 65536;

  localparam logic [15:0] CLIP_RESET = 16'd655;
  localparam logic [14:0] EXPO_RESET = 15'd2048;

  localparam logic REG_CLIP = 1'b0;
  localparam logic REG_EXPO = 1'b1;

  localparam logic CMD_COUNT = 1'b0;
  localparam logic CMD_MAP   = 1'b1;

  localparam int DIV_STEPS = 17;
  localparam logic [23:0] CUM_MAX = 24'hFFFFFF;
  localparam logic [63:0] EXP_STEP = 64'd1070838488;

  typedef logic [15:0] log_tab_t [256];
  typedef logic [16:0] exp_tab_t [256];

  typedef struct packed {
    logic        valid;
    logic [15:0] quo;
  } div_res_t;

  function automatic log_tab_t log_table();
    logic [63:0] x;
    logic [15:0] f;
    log_tab_t    t;
    for (int i = 0; i < 256; i++) begin
      x = 64'(256 + i) << 22;
      f = '0;
      for (int b = 0; b < 16; b++) begin
        x = (x * x) >> 30;
        f = f << 1;
        if (x >= (64'd2 << 30)) begin
          x = x >> 1;
          f[0] = 1'b1;
        end
      end
      t[i] = f;
    end
    return t;
  endfunction

  function automatic exp_tab_t exp_table();
    logic [63:0] v;
    exp_tab_t    t;
    v = 64'd1 << 30;
    for (int i = 0; i < 256; i++) begin
      t[i] = 17'((v + (64'd1 << 13)) >> 14);
      v = (v * EXP_STEP) >> 30;
    end
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = log_table();
  localparam exp_tab_t EXP_TAB = exp_table();

endpackage
`default_nettype wire

/* src/wthe_ram.sv */
// Generic simple dual-port RAM with registered read.
`default_nettype none
module wthe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/wthe_div.sv */
// Bit-serial divider for bin probability count * 2^16 / total, clamped to 16 bits.
`default_nettype none
module wthe_div #(
  parameter int CW = 17
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [CW-1:0]     dividend,
  input  wire logic [CW-1:0]     divisor,
  output wthe_pkg::div_res_t     res
);

  logic [CW:0]  rem;
  logic [16:0]  quo;
  logic [4:0]   cnt;
  logic         busy;
  logic         ge;
  logic [CW:0]  rem_sub;
  logic [16:0]  quo_next;

  always_comb begin
    ge       = rem >= {1'b0, divisor};
    rem_sub  = ge ? (rem - {1'b0, divisor}) : rem;
    quo_next = {quo[15:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      res.valid <= 1'b0;
      if (start) begin
        rem  <= {1'b0, dividend};
        quo  <= '0;
        cnt  <= 5'(wthe_pkg::DIV_STEPS);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= {rem_sub[CW-1:0], 1'b0};
        quo <= quo_next;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy      <= 1'b0;
          res.valid <= 1'b1;
          if (divisor == '0) begin
            res.quo <= '0;
          end else if (quo_next[16]) begin
            res.quo <= 16'hFFFF;
          end else begin
            res.quo <= quo_next[15:0];
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

/* src/wthe_weight.sv */
// Three-stage pipeline: probability to weight p^r through log2 and exp2 tables.
`default_nettype none
module wthe_weight (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic [15:0] prob,
  input  wire logic [14:0] expo,
  output logic             w_valid,
  output logic [16:0]      weight
);

  logic [3:0]  lead;
  logic [15:0] norm;
  logic [7:0]  idx;
  logic [20:0] nl;
  logic        s1_valid, s1_zero;
  logic [20:0] s1_nl;
  logic        s2_valid, s2_zero;
  logic [23:0] s2_t;
  logic [35:0] prod;
  logic [7:0]  ti;
  logic [16:0] ev;

  always_comb begin
    lead = '0;
    for (int b = 0; b < 16; b++) begin
      if (prob[b]) begin
        lead = 4'(b);
      end
    end
    norm = prob << (4'd15 - lead);
    idx  = norm[14:7];
    nl   = {5'(5'd16 - {1'b0, lead}), 16'b0} - 21'(wthe_pkg::LOG_TAB[idx]);
    prod = 36'(s1_nl) * 36'(expo);
    ti   = s2_t[23:16];
    ev   = wthe_pkg::EXP_TAB[s2_t[15:8]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      w_valid  <= 1'b0;
    end else begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      w_valid  <= s2_valid;
    end
    s1_nl   <= nl;
    s1_zero <= prob == '0;
    s2_t    <= prod[35:12];
    s2_zero <= s1_zero;
    if (s2_zero) begin
      weight <= (expo == '0) ? 17'd65536 : 17'd0;
    end else if (ti > 8'd16) begin
      weight <= '0;
    end else begin
      weight <= ev >> ti[4:0];
    end
  end

endmodule
`default_nettype wire

/* src/weighted_threshold_hist_equalizer_unit.sv */
// Top level of the weighted threshold histogram equalizer.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, cmd, pixel, last      | request in
//  out     | out_valid, out_stall, mapped_pixel, last_res | request out
//  cfg     | cfg_wr_en, cfg_index, cfg_data            | write in
//
// Count request: histogram RAM read, then write back.
// Map request: level map RAM read, then output register.
// Build after the last count, for each bin: RAM read, divider wait, 3-stage weight
// pipeline, accumulate; no request is accepted meanwhile.
// Reset clears bin valid bits, pixel total and map-ready; a stalled output holds.
`default_nettype none
module weighted_threshold_hist_equalizer_unit #(
  parameter int GREY_LEVELS = wthe_pkg::GREY_LEVELS_DEF,
  parameter int MAX_PIXELS  = wthe_pkg::MAX_PIXELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        cmd,
  input  wire logic [7:0]  pixel,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       mapped_pixel,
  output logic             last_res,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int LW = $clog2(GREY_LEVELS);
  localparam int CW = $clog2(MAX_PIXELS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_CNT, S_MAP, S_BRD, S_BLD, S_BDIV, S_BWT
  } state_t;

  state_t state;

  logic [15:0]    clip;
  logic [14:0]    expo;
  logic [CW-1:0]  pixel_total;
  logic           map_ready;
  logic [LW-1:0]  lvl_in, lvl_r, bin;
  logic           last_r;
  logic [23:0]    cum;
  logic [GREY_LEVELS-1:0] hist_vld;
  logic           hist_vld_rd;

  logic           accept;
  logic [LW-1:0]  hist_raddr;
  logic [CW-1:0]  hist_rdata, hist_wdata, count;
  logic           hist_we;
  logic [7:0]     map_rdata, map_wdata;
  logic           map_we;

  logic           div_start;
  wthe_pkg::div_res_t div_res;
  logic [15:0]    prob;
  logic           w_start, w_valid;
  logic [16:0]    weight;
  logic [24:0]    cum_sum;
  logic [23:0]    cum_next;
  logic [31:0]    m32;

  always_comb begin
    in_stall = (state != S_IDLE) || (out_valid && out_stall);
    accept   = in_valid && !in_stall;
    lvl_in   = ({1'b0, pixel} >= 9'(GREY_LEVELS)) ? LW'(GREY_LEVELS - 1) : pixel[LW-1:0];
    hist_raddr = (state == S_IDLE) ? lvl_in : bin;
    count    = hist_vld_rd ? hist_rdata : '0;
    hist_wdata = (count < CW'(MAX_PIXELS)) ? count + CW'(1) : count;
    hist_we  = state == S_CNT;
    div_start = state == S_BLD;
    prob     = (div_res.quo > clip) ? clip : div_res.quo;
    w_start  = (state == S_BDIV) && div_res.valid;
    cum_sum  = {1'b0, cum} + 25'(weight);
    cum_next = cum_sum[24] ? wthe_pkg::CUM_MAX : cum_sum[23:0];
    m32      = {cum_next, 8'b0} - {8'b0, cum_next};
    map_wdata = (m32[31:16] > 16'd255) ? 8'd255 : m32[23:16];
    map_we   = (state == S_BWT) && w_valid;
  end

  wthe_ram #(.WIDTH(CW), .DEPTH(GREY_LEVELS)) u_hist (
    .clk(clk), .we(hist_we), .waddr(lvl_r), .wdata(hist_wdata),
    .raddr(hist_raddr), .rdata(hist_rdata)
  );

  wthe_ram #(.WIDTH(8), .DEPTH(GREY_LEVELS)) u_map (
    .clk(clk), .we(map_we), .waddr(bin), .wdata(map_wdata),
    .raddr(lvl_in), .rdata(map_rdata)
  );

  wthe_div #(.CW(CW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(count),
    .divisor(pixel_total), .res(div_res)
  );

  wthe_weight u_weight (
    .clk(clk), .rst(rst), .in_valid(w_start), .prob(prob), .expo(expo),
    .w_valid(w_valid), .weight(weight)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      clip        <= wthe_pkg::CLIP_RESET;
      expo        <= wthe_pkg::EXPO_RESET;
      pixel_total <= '0;
      map_ready   <= 1'b0;
      hist_vld    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          wthe_pkg::REG_CLIP: clip <= cfg_data;
          wthe_pkg::REG_EXPO: expo <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      hist_vld_rd <= hist_vld[hist_raddr];
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            lvl_r  <= lvl_in;
            last_r <= last;
            state  <= (cmd == wthe_pkg::CMD_COUNT) ? S_CNT : S_MAP;
          end
        end
        S_CNT: begin
          hist_vld[lvl_r] <= 1'b1;
          if (pixel_total < CW'(MAX_PIXELS)) begin
            pixel_total <= pixel_total + CW'(1);
          end
          if (last_r) begin
            bin   <= '0;
            cum   <= '0;
            state <= S_BRD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_MAP: begin
          out_valid    <= 1'b1;
          mapped_pixel <= map_ready ? map_rdata : 8'd0;
          last_res     <= last_r;
          state        <= S_IDLE;
        end
        S_BRD: state <= S_BLD;
        S_BLD: begin
          hist_vld[bin] <= 1'b0;
          state <= S_BDIV;
        end
        S_BDIV: begin
          if (div_res.valid) begin
            state <= S_BWT;
          end
        end
        S_BWT: begin
          if (w_valid) begin
            cum <= cum_next;
            if (bin == LW'(GREY_LEVELS - 1)) begin
              pixel_total <= '0;
              map_ready   <= 1'b1;
              state       <= S_IDLE;
            end else begin
              bin   <= bin + LW'(1);
              state <= S_BRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_out_from_map: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_MAP))
    else $error("output appeared without a map read");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_CNT || state == S_MAP))
    else $error("accepted request did not start work");

  a_build_clears_total: assert property (@(posedge clk) disable iff (rst)
    (state == S_BWT && w_valid && bin == LW'(GREY_LEVELS - 1)) |=>
      (pixel_total == '0 && map_ready && hist_vld == '0))
    else $error("build did not leave histogram cleared");

endmodule
`default_nettype wire
